FILE: rtl/stm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse triplet multiply - shared types and constants
// Word formats, action and result codes for the sparse product block.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int MaxDim     = 16;
  localparam int MaxEntries = 64;
  localparam int Cells      = MaxDim * MaxDim;
  localparam int DimW       = $clog2(MaxDim);
  localparam int EntW       = $clog2(MaxEntries);
  localparam int CellW      = $clog2(Cells);

  localparam logic [2:0] ActLoadA  = 3'd0;
  localparam logic [2:0] ActLoadB  = 3'd1;
  localparam logic [2:0] ActComp   = 3'd2;
  localparam logic [2:0] ActRead   = 3'd3;
  localparam logic [2:0] ActClear  = 3'd4;

  localparam logic [1:0] KindDone  = 2'd0;
  localparam logic [1:0] KindMis   = 2'd1;
  localparam logic [1:0] KindEntry = 2'd2;
  localparam logic [1:0] KindEnd   = 2'd3;

  localparam logic [2:0] RegARows  = 3'd0;
  localparam logic [2:0] RegACols  = 3'd1;
  localparam logic [2:0] RegBRows  = 3'd2;
  localparam logic [2:0] RegBCols  = 3'd3;
  localparam logic [2:0] RegCommon = 3'd4;

  typedef struct packed {
    logic        [2:0]  action;
    logic        [3:0]  entry_row;
    logic        [3:0]  entry_col;
    logic signed [31:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  result_kind;
    logic        [3:0]  out_row;
    logic        [3:0]  out_col;
    logic signed [31:0] out_value;
    logic               last_entry;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic [31:0]     value;
  } trip_t;

endpackage

FILE: rtl/sparse_triplet_multiply.sv
// ----------------------------------------------------------------------------
// Sparse triplet multiply
// Loads two triplet lists, multiplies them into a dense accumulator memory
// and streams back the cells that differ from the background value.
// ----------------------------------------------------------------------------
// Channel | Signals                      | Word
// in      | in_valid, in_ready, in_data  | stm_pkg::in_word_t
// out     | out_valid, out_ready, out_data | stm_pkg::out_word_t
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | 3-bit index, 32-bit data
//
// Loads and clears are taken in the idle state. Compute (when A columns match
// B rows) sets the accumulator memory to the background value, then for each
// A entry (first_count) does an A read, a walk over the B list (B read,
// multiply, read-modify-write of one cell) and a pipeline drain, and then
// posts the done word. A read scans the accumulator memory one cell a cycle.
// Reset is synchronous; memories hold no reset state.
// A waiting output word blocks further input until it is taken.
// ----------------------------------------------------------------------------
module sparse_triplet_multiply (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stm_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stm_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_AREAD = 7'b0000100,
    S_PAIR  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIND  = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  a_rows, a_cols, b_rows, b_cols;
  logic [31:0] common_value;

  // list and accumulator memories
  stm_pkg::trip_t list_a [stm_pkg::MaxEntries];
  stm_pkg::trip_t list_b [stm_pkg::MaxEntries];
  logic [31:0]    acc    [stm_pkg::Cells];

  logic [stm_pkg::EntW:0]    first_count, second_count;
  logic [stm_pkg::CellW:0]   read_position;
  logic                      overflow_flag, product_ready;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_ready  = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= 5'd1; a_cols <= 5'd1; b_rows <= 5'd1; b_cols <= 5'd1;
      common_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stm_pkg::RegARows:  a_rows <= cfg_data[4:0];
        stm_pkg::RegACols:  a_cols <= cfg_data[4:0];
        stm_pkg::RegBRows:  b_rows <= cfg_data[4:0];
        stm_pkg::RegBCols:  b_cols <= cfg_data[4:0];
        stm_pkg::RegCommon: common_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped bounds
  logic [4:0] rows_lim, cols_lim;
  assign rows_lim = (a_rows > 5'(stm_pkg::MaxDim)) ? 5'(stm_pkg::MaxDim) : a_rows;
  assign cols_lim = (b_cols > 5'(stm_pkg::MaxDim)) ? 5'(stm_pkg::MaxDim) : b_cols;

  // list writes
  wire in_acc = in_valid && in_ready;
  wire is_bg  = (in_data.entry_value == common_value);
  stm_pkg::trip_t new_trip;
  assign new_trip = '{row: in_data.entry_row, col: in_data.entry_col,
                      value: in_data.entry_value};

  always_ff @(posedge clk) begin
    if (in_acc && !is_bg && in_data.action == stm_pkg::ActLoadA &&
        first_count < (stm_pkg::EntW+1)'(stm_pkg::MaxEntries))
      list_a[first_count[stm_pkg::EntW-1:0]] <= new_trip;
    if (in_acc && !is_bg && in_data.action == stm_pkg::ActLoadB &&
        second_count < (stm_pkg::EntW+1)'(stm_pkg::MaxEntries))
      list_b[second_count[stm_pkg::EntW-1:0]] <= new_trip;
  end

  // compute pipeline: B read (1) -> product reg + acc read (2) -> write
  logic [stm_pkg::EntW:0]   ai, bj;
  stm_pkg::trip_t           a_q, b_q;
  logic                     b_v;
  logic [31:0]              prod;
  logic [stm_pkg::CellW-1:0] p_cell;
  logic                     p_v;
  logic [31:0]              acc_q;
  logic [stm_pkg::CellW-1:0] w_cell;
  logic                     w_v;
  logic [31:0]              w_prod;

  logic [stm_pkg::CellW:0]  fill;
  logic [stm_pkg::CellW:0]  scan;
  logic [stm_pkg::CellW-1:0] rd_addr;
  logic [31:0]              rd_q;

  always_ff @(posedge clk) begin
    a_q <= list_a[ai[stm_pkg::EntW-1:0]];
    b_q <= list_b[bj[stm_pkg::EntW-1:0]];
  end

  // forwarding from the write stage into the pending read-modify-write:
  // a cell read in the same cycle as the previous write sees the old value
  logic [31:0]               acc_cur;
  logic                      fw_v;
  logic [stm_pkg::CellW-1:0] fw_cell;
  logic [31:0]               fw_val;
  always_comb begin
    acc_cur = (fw_v && fw_cell == w_cell) ? fw_val : acc_q;
  end

  always_ff @(posedge clk) begin
    if (rst) fw_v <= 1'b0;
    else fw_v <= w_v;
    fw_cell <= w_cell;
    fw_val  <= acc_cur + w_prod;
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL)
      acc[fill[stm_pkg::CellW-1:0]] <= common_value;
    else if (w_v)
      acc[w_cell] <= acc_cur + w_prod;
    rd_q <= acc[rd_addr];
  end
  assign acc_q = rd_q;

  // p_cell feeds the read address during compute; scan otherwise
  assign rd_addr = (state == S_PAIR || state == S_DRAIN) ? p_cell
                                                          : scan[stm_pkg::CellW-1:0];

  // scan bookkeeping: first hit and look-ahead for last flag
  logic        have_hit;
  logic [stm_pkg::CellW-1:0] hit_cell;
  logic [31:0] hit_val;
  logic        scan_v;
  logic [stm_pkg::CellW-1:0] scan_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      first_count <= '0; second_count <= '0;
      read_position <= '0; overflow_flag <= 1'b0; product_ready <= 1'b0;
      b_v <= 1'b0; p_v <= 1'b0; w_v <= 1'b0; scan_v <= 1'b0; have_hit <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.action)
              stm_pkg::ActLoadA: if (!is_bg) begin
                if (first_count < (stm_pkg::EntW+1)'(stm_pkg::MaxEntries))
                  first_count <= first_count + 1'b1;
                else overflow_flag <= 1'b1;
              end
              stm_pkg::ActLoadB: if (!is_bg) begin
                if (second_count < (stm_pkg::EntW+1)'(stm_pkg::MaxEntries))
                  second_count <= second_count + 1'b1;
                else overflow_flag <= 1'b1;
              end
              stm_pkg::ActComp: begin
                if (a_cols != b_rows) begin
                  product_ready <= 1'b0;
                  out_valid <= 1'b1;
                  out_data <= '{result_kind: stm_pkg::KindMis, out_row: '0,
                    out_col: '0, out_value: '0, last_entry: 1'b0,
                    overflow: overflow_flag};
                end else begin
                  fill <= '0; state <= S_FILL;
                end
              end
              stm_pkg::ActRead: begin
                if (!product_ready ||
                    read_position >= (stm_pkg::CellW+1)'(stm_pkg::Cells)) begin
                  read_position <= (stm_pkg::CellW+1)'(stm_pkg::Cells);
                  out_valid <= 1'b1;
                  out_data <= '{result_kind: stm_pkg::KindEnd, out_row: '0,
                    out_col: '0, out_value: '0, last_entry: 1'b1,
                    overflow: overflow_flag};
                end else begin
                  scan <= read_position; scan_v <= 1'b0; have_hit <= 1'b0;
                  state <= S_SCAN;
                end
              end
              stm_pkg::ActClear: begin
                first_count <= '0; second_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          fill <= fill + 1'b1;
          if (fill == (stm_pkg::CellW+1)'(stm_pkg::Cells - 1)) begin
            ai <= '0; bj <= '0;
            state <= (first_count == '0 || second_count == '0) ? S_FIND : S_AREAD;
          end
        end
        S_AREAD: begin
          // a_q valid next cycle; b read address bj=0
          bj <= '0; b_v <= 1'b0; p_v <= 1'b0; w_v <= 1'b0;
          state <= S_PAIR;
        end
        S_PAIR: begin
          // stage 1 issue B read of bj
          b_v <= (bj < second_count);
          if (bj < second_count) bj <= bj + 1'b1;
          // stage 2: product, cell; acc read issued via p_cell
          p_v <= b_v && (a_q.col == b_q.row) && ({1'b0, a_q.row} < rows_lim) &&
                 ({1'b0, b_q.col} < cols_lim);
          prod <= a_q.value * b_q.value;
          p_cell <= {a_q.row, b_q.col};
          // stage 3: write back
          w_v <= p_v; w_cell <= p_cell; w_prod <= prod;
          if (!b_v && !p_v && !w_v && bj >= second_count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          b_v <= 1'b0; p_v <= 1'b0; w_v <= 1'b0;
          if (ai + 1'b1 >= first_count) begin
            state <= S_FIND;
          end else begin
            ai <= ai + 1'b1; state <= S_AREAD;
          end
        end
        S_FIND: begin
          product_ready <= 1'b1; read_position <= '0;
          out_valid <= 1'b1;
          out_data <= '{result_kind: stm_pkg::KindDone, out_row: '0,
            out_col: '0, out_value: '0, last_entry: 1'b0,
            overflow: overflow_flag};
          state <= S_IDLE;
        end
        S_SCAN: begin
          // rd_q holds cell scan_cell when scan_v
          if (scan < (stm_pkg::CellW+1)'(stm_pkg::Cells)) scan <= scan + 1'b1;
          scan_v <= (scan < (stm_pkg::CellW+1)'(stm_pkg::Cells));
          scan_cell <= scan[stm_pkg::CellW-1:0];
          if (scan_v && rd_q != common_value) begin
            if (!have_hit) begin
              have_hit <= 1'b1; hit_cell <= scan_cell; hit_val <= rd_q;
            end else begin
              out_valid <= 1'b1;
              out_data <= '{result_kind: stm_pkg::KindEntry,
                out_row: hit_cell[stm_pkg::CellW-1 -: 4],
                out_col: hit_cell[3:0], out_value: hit_val, last_entry: 1'b0,
                overflow: overflow_flag};
              read_position <= (stm_pkg::CellW+1)'(hit_cell) + 1'b1;
              state <= S_IDLE;
            end
          end else if (!scan_v && scan >= (stm_pkg::CellW+1)'(stm_pkg::Cells)) begin
            out_valid <= 1'b1;
            if (have_hit) begin
              out_data <= '{result_kind: stm_pkg::KindEntry,
                out_row: hit_cell[stm_pkg::CellW-1 -: 4],
                out_col: hit_cell[3:0], out_value: hit_val, last_entry: 1'b1,
                overflow: overflow_flag};
              read_position <= (stm_pkg::CellW+1)'(hit_cell) + 1'b1;
            end else begin
              read_position <= (stm_pkg::CellW+1)'(stm_pkg::Cells);
              out_data <= '{result_kind: stm_pkg::KindEnd, out_row: '0,
                out_col: '0, out_value: '0, last_entry: 1'b1,
                overflow: overflow_flag};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/tb_sparse_triplet_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet multiply - self-checking testbench
// Loads random triplet lists, computes products and reads back the non
// background cells. A local product model predicts each returned word, and
// words are compared field by field in order under random idling.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_multiply;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  stm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stm_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sparse_triplet_multiply DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the block's state
  logic [4:0]  dim_a_rows, dim_a_cols, dim_b_rows, dim_b_cols;
  logic [31:0] background;
  stm_pkg::trip_t list_a[stm_pkg::MaxEntries];
  stm_pkg::trip_t list_b[stm_pkg::MaxEntries];
  int          count_a, count_b;
  logic [31:0] acc[stm_pkg::Cells];
  int          scan_pos;
  bit          sticky_ovf, have_product;

  stm_pkg::in_word_t  pending_words[$];
  stm_pkg::out_word_t due_words[$];
  int        fail_count = 0;
  bit        calm = 1'b0;     // no idling in the closing stretch
  int        in_gap = 0, out_gap = 0;

  function automatic void add_pending(input stm_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void add_due(input stm_pkg::out_word_t w);
    due_words = {due_words, w};
  endfunction

  function automatic int next_live(int from);
    for (int p = from; p < stm_pkg::Cells; p++)
      if (acc[p] != background) return p;
    return stm_pkg::Cells;
  endfunction

  function automatic stm_pkg::out_word_t make_word(logic [1:0] kind, int row, int col,
                                                   logic [31:0] value, bit last);
    stm_pkg::out_word_t w;
    w.result_kind = kind;
    w.out_row = row[3:0];
    w.out_col = col[3:0];
    w.out_value = value;
    w.last_entry = last;
    w.overflow = sticky_ovf;
    return w;
  endfunction

  // Predict the words caused by one accepted input word
  task automatic predict_product(input stm_pkg::in_word_t w);
    int rows, cols, p;
    stm_pkg::trip_t t;
    t.row = w.entry_row;
    t.col = w.entry_col;
    t.value = w.entry_value;
    case (w.action)
      stm_pkg::ActLoadA, stm_pkg::ActLoadB: begin
        if (w.entry_value != background) begin
          if ((w.action == stm_pkg::ActLoadA ? count_a : count_b) >= stm_pkg::MaxEntries)
            sticky_ovf = 1'b1;
          else if (w.action == stm_pkg::ActLoadA) begin
            list_a[count_a] = t;
            count_a++;
          end else begin
            list_b[count_b] = t;
            count_b++;
          end
        end
      end
      stm_pkg::ActComp: begin
        if (dim_a_cols != dim_b_rows) begin
          have_product = 1'b0;
          add_due(make_word(stm_pkg::KindMis, 0, 0, 0, 1'b0));
        end else begin
          rows = (dim_a_rows > stm_pkg::MaxDim) ? stm_pkg::MaxDim : dim_a_rows;
          cols = (dim_b_cols > stm_pkg::MaxDim) ? stm_pkg::MaxDim : dim_b_cols;
          for (int c = 0; c < stm_pkg::Cells; c++) acc[c] = background;
          for (int i = 0; i < count_a; i++)
            for (int j = 0; j < count_b; j++)
              if (list_a[i].col == list_b[j].row && list_a[i].row < rows &&
                  list_b[j].col < cols) begin
                p = list_a[i].row * stm_pkg::MaxDim + list_b[j].col;
                acc[p] = acc[p] + list_a[i].value * list_b[j].value;
              end
          have_product = 1'b1;
          scan_pos = 0;
          add_due(make_word(stm_pkg::KindDone, 0, 0, 0, 1'b0));
        end
      end
      stm_pkg::ActRead: begin
        p = have_product ? next_live(scan_pos) : stm_pkg::Cells;
        if (p >= stm_pkg::Cells) begin
          scan_pos = stm_pkg::Cells;
          add_due(make_word(stm_pkg::KindEnd, 0, 0, 0, 1'b1));
        end else begin
          scan_pos = p + 1;
          add_due(make_word(stm_pkg::KindEntry, p / stm_pkg::MaxDim,
                            p % stm_pkg::MaxDim, acc[p],
                            next_live(p + 1) >= stm_pkg::Cells));
        end
      end
      stm_pkg::ActClear: begin
        count_a = 0;
        count_b = 0;
      end
      default: ;
    endcase
  endtask

  // Driver: one word from the queue, held until taken
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_product(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 16);
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each taken word with the oldest prediction
  always @(posedge clk) begin
    stm_pkg::out_word_t exp_w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("unexpected word %h", out_data);
          fail_count++;
        end else begin
          exp_w = due_words.pop_front();
          if (out_data.result_kind !== exp_w.result_kind) begin
            $error("result_kind exp %0d got %0d", exp_w.result_kind, out_data.result_kind);
            fail_count++;
          end
          if (out_data.out_row !== exp_w.out_row) begin
            $error("out_row exp %0d got %0d", exp_w.out_row, out_data.out_row);
            fail_count++;
          end
          if (out_data.out_col !== exp_w.out_col) begin
            $error("out_col exp %0d got %0d", exp_w.out_col, out_data.out_col);
            fail_count++;
          end
          if (out_data.out_value !== exp_w.out_value) begin
            $error("out_value exp %h got %h", exp_w.out_value, out_data.out_value);
            fail_count++;
          end
          if (out_data.last_entry !== exp_w.last_entry) begin
            $error("last_entry exp %0d got %0d", exp_w.last_entry, out_data.last_entry);
            fail_count++;
          end
          if (out_data.overflow !== exp_w.overflow) begin
            $error("overflow exp %0d got %0d", exp_w.overflow, out_data.overflow);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 16);
      end
    end
  end

  function automatic stm_pkg::in_word_t word_of(logic [2:0] act, int row, int col,
                                                logic [31:0] value);
    stm_pkg::in_word_t w;
    w.action = act;
    w.entry_row = row[3:0];
    w.entry_col = col[3:0];
    w.entry_value = value;
    return w;
  endfunction

  // Values: a third small so products stay readable, the rest full range, extremes or the background
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return background;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 20) - 10;
    endcase
  endfunction

  // Register write; only called while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      stm_pkg::RegARows:  dim_a_rows = value[4:0];
      stm_pkg::RegACols:  dim_a_cols = value[4:0];
      stm_pkg::RegBRows:  dim_b_rows = value[4:0];
      stm_pkg::RegBCols:  dim_b_cols = value[4:0];
      stm_pkg::RegCommon: background = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || due_words.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Loads plus compute plus a random number of reads; long batches carry no clear so
  // that the lists overfill
  task automatic queue_batch(input int loads, input int span);
    int r;
    for (int k = 0; k < loads; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0 && loads <= stm_pkg::MaxEntries)
        add_pending(word_of(stm_pkg::ActClear, 0, 0, 0));
      else if (r == 1) add_pending(word_of(3'($urandom_range(5, 7)),
                                           $urandom_range(0, 15),
                                           $urandom_range(0, 15), $urandom()));
      else add_pending(word_of(r[0] ? stm_pkg::ActLoadA : stm_pkg::ActLoadB,
                               $urandom_range(0, span), $urandom_range(0, span),
                               pick_value()));
    end
    add_pending(word_of(stm_pkg::ActComp, 0, 0, 0));
    for (int k = $urandom_range(2, 14); k > 0; k--)
      add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
  endtask

  initial begin
    dim_a_rows = 1; dim_a_cols = 1; dim_b_rows = 1; dim_b_cols = 1;
    background = '0;
    count_a = 0; count_b = 0; scan_pos = 0;
    sticky_ovf = 1'b0; have_product = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: read before product, reset dims, extremes of the fields
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActLoadA, 0, 0, 32'd5));
    add_pending(word_of(stm_pkg::ActLoadB, 0, 0, 32'd7));
    add_pending(word_of(stm_pkg::ActLoadA, 0, 0, 32'd0));
    add_pending(word_of(stm_pkg::ActLoadA, 15, 15, 32'hFFFF_FFFF));
    add_pending(word_of(3'd7, 15, 15, 32'hFFFF_FFFF));
    add_pending(word_of(stm_pkg::ActComp, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActClear, 0, 0, 0));
    wait_idle();

    write_reg(stm_pkg::RegARows, 16); write_reg(stm_pkg::RegACols, 16);
    write_reg(stm_pkg::RegBRows, 16); write_reg(stm_pkg::RegBCols, 16);
    write_reg(stm_pkg::RegCommon, 32'h8000_0000);
    add_pending(word_of(stm_pkg::ActLoadA, 15, 15, 32'h7FFF_FFFF));
    add_pending(word_of(stm_pkg::ActLoadB, 15, 15, 32'h7FFF_FFFF));
    add_pending(word_of(stm_pkg::ActLoadA, 3, 15, 32'h8000_0000));
    add_pending(word_of(stm_pkg::ActComp, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    wait_idle();
    // Background changed after compute: scan uses the new value
    write_reg(stm_pkg::RegCommon, 32'h7FFF_FFFF);
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActClear, 0, 0, 0));
    wait_idle();
    // Mismatch, then a read reports end
    write_reg(stm_pkg::RegBRows, 3);
    add_pending(word_of(stm_pkg::ActComp, 0, 0, 0));
    add_pending(word_of(stm_pkg::ActRead, 0, 0, 0));
    wait_idle();
    // Oversized dims saturate
    write_reg(stm_pkg::RegARows, 31); write_reg(stm_pkg::RegACols, 31);
    write_reg(stm_pkg::RegBRows, 31); write_reg(stm_pkg::RegBCols, 31);
    write_reg(stm_pkg::RegCommon, 0);
    queue_batch(20, 15);
    wait_idle();

    // Random phases with varied settings; some batches overfill the lists
    for (int ph = 0; ph < 26; ph++) begin
      if (ph == 22) calm = 1'b1;
      write_reg(stm_pkg::RegARows, $urandom_range(1, 16));
      write_reg(stm_pkg::RegBCols, $urandom_range(1, 16));
      write_reg(stm_pkg::RegACols, $urandom_range(1, 16));
      write_reg(stm_pkg::RegBRows, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                                : 32'(dim_a_cols));
      write_reg(stm_pkg::RegCommon, ($urandom_range(0, 2) == 0) ? $urandom() : 32'd0);
      add_pending(word_of(stm_pkg::ActClear, 0, 0, 0));
      for (int b = 0; b < 3; b++)
        queue_batch((ph % 13 == 12 && b == 0) ? 160 : $urandom_range(1, 10),
                    $urandom_range(1, 15));
      wait_idle();
    end
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
